// ===== rtl/jpeg_huffman_symbol_encoder_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the JPEG Huffman symbol encoder
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef JPEG_HUFFMAN_SYMBOL_ENCODER_CORE_MACROS_SVH
`define JPEG_HUFFMAN_SYMBOL_ENCODER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JHSE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JHSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jhse_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JPEG Huffman symbol encoder package
// Shared widths, operation codes, the queued item type and helper functions.
// ---------------------------------------------------------------------------
package jhse_pkg;

	localparam int SYM_W     = 8;
	localparam int CODE_W    = 16;
	localparam int LEN_W     = 5;
	localparam int RUN_W     = 4;
	localparam int AMP_W     = 12;
	localparam int MAG_W     = 11;
	localparam int CAT_W     = 4;
	localparam int CHUNK_W   = 27;
	localparam int ENTRY_W   = LEN_W + CODE_W;
	localparam int DC_DEPTH  = 16;
	localparam int AC_DEPTH  = 256;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_WR_DC  = 2'd0,
		OP_WR_AC  = 2'd1,
		OP_ENC_DC = 2'd2,
		OP_ENC_AC = 2'd3
	} jhse_op_t;

	// One classified request on its way from the front to the back.
	typedef struct packed {
		jhse_op_t          op;
		logic [SYM_W-1:0]  addr;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic [CAT_W-1:0]  cat;
		logic [MAG_W-1:0]  extra;
		logic              bend;
	} jhse_item_t;

	// Magnitude category: position of the highest set bit, plus one.
	function automatic logic [CAT_W-1:0] jhse_category(input logic [MAG_W-1:0] mag);
		logic [CAT_W-1:0] cat;
		cat = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mag[i]) begin
				cat = CAT_W'(i + 1);
			end
		end
		return cat;
	endfunction

endpackage

// ===== rtl/jhse_symbol_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Symbol request channel
// Valid/ready channel carrying one table write or encode request.
// ---------------------------------------------------------------------------
interface jhse_symbol_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        op;
	logic [jhse_pkg::SYM_W-1:0]        table_symbol;
	logic [jhse_pkg::CODE_W-1:0]       code_bits;
	logic [jhse_pkg::LEN_W-1:0]        code_length;
	logic [jhse_pkg::RUN_W-1:0]        run_length;
	logic signed [jhse_pkg::AMP_W-1:0] amplitude;
	logic                              block_end_in;

	modport source (
		output valid, op, table_symbol, code_bits, code_length, run_length,
			amplitude, block_end_in,
		input  ready
	);

	modport sink (
		input  valid, op, table_symbol, code_bits, code_length, run_length,
			amplitude, block_end_in,
		output ready
	);
endinterface

// ===== rtl/jhse_chunk_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bit chunk result channel
// Valid/ready channel carrying one encoded chunk with its length and flags.
// ---------------------------------------------------------------------------
interface jhse_chunk_if;
	logic                         valid;
	logic                         ready;
	logic [jhse_pkg::CHUNK_W-1:0] bit_chunk;
	logic [jhse_pkg::LEN_W-1:0]   chunk_length;
	logic                         block_end_out;
	logic                         code_missing;

	modport source (
		output valid, bit_chunk, chunk_length, block_end_out, code_missing,
		input  ready
	);

	modport sink (
		input  valid, bit_chunk, chunk_length, block_end_out, code_missing,
		output ready
	);
endinterface

// ===== rtl/jhse_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ---------------------------------------------------------------------------
module jhse_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/jhse_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Encoder front end
// Accepts requests, normalizes table writes and classifies amplitudes.
// ---------------------------------------------------------------------------
module jhse_front #(
	parameter int MAX_CODE_LEN = 16,
	parameter int AMP_BITS     = 11
) (
	jhse_symbol_if.sink          symbol,
	input  logic                 queue_full,
	output logic                 push,
	output jhse_pkg::jhse_item_t push_item
);
	import jhse_pkg::*;

	localparam int AMP_LIM = (AMP_BITS >= 11) ? 2047 : ((1 << AMP_BITS) - 1);

	logic              neg;
	logic [AMP_W-1:0]  mag_raw;
	logic [MAG_W-1:0]  mag;
	logic [CAT_W-1:0]  cat;
	logic [MAG_W-1:0]  extra;
	logic [LEN_W-1:0]  len_sat;
	logic [CODE_W-1:0] code_mask;
	jhse_op_t          op;
	logic              drop;

	assign op = jhse_op_t'(symbol.op);

	// Negating the most negative value wraps back to 0x800, its true magnitude.
	assign neg     = symbol.amplitude[AMP_W-1];
	assign mag_raw = neg ? (AMP_W'(0) - symbol.amplitude) : symbol.amplitude;
	assign mag     = (mag_raw > AMP_W'(AMP_LIM)) ? MAG_W'(AMP_LIM) : mag_raw[MAG_W-1:0];
	assign cat     = jhse_category(mag);
	assign extra   = neg ? (~mag & ~({MAG_W{1'b1}} << cat)) : mag;

	assign len_sat   = (symbol.code_length > LEN_W'(MAX_CODE_LEN)) ?
		LEN_W'(MAX_CODE_LEN) : symbol.code_length;
	assign code_mask = ~({CODE_W{1'b1}} << len_sat);

	// DC writes beyond the sixteen categories are accepted and discarded.
	assign drop = (op == OP_WR_DC) && (symbol.table_symbol >= SYM_W'(DC_DEPTH));

	assign symbol.ready = !queue_full;
	assign push         = symbol.valid && !queue_full && !drop;

	always_comb begin
		push_item       = '0;
		push_item.op    = op;
		push_item.code  = symbol.code_bits & code_mask;
		push_item.len   = len_sat;
		push_item.cat   = cat;
		push_item.extra = extra;
		push_item.bend  = symbol.block_end_in;
		case (op)
			OP_WR_DC, OP_WR_AC: push_item.addr = symbol.table_symbol;
			OP_ENC_DC:          push_item.addr = SYM_W'(cat);
			OP_ENC_AC:          push_item.addr = {symbol.run_length, cat};
			default:            push_item.addr = symbol.table_symbol;
		endcase
	end

endmodule

// ===== rtl/jhse_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Request queue
// Small FIFO that decouples the front end from the table lookup.
// ---------------------------------------------------------------------------
module jhse_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  jhse_pkg::jhse_item_t push_item,
	output logic                 full,
	output logic                 not_empty,
	input  logic                 pop,
	output jhse_pkg::jhse_item_t head
);
	import jhse_pkg::*;

	`include "jpeg_huffman_symbol_encoder_core_macros.svh"

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	jhse_item_t       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`JHSE_ASSERT_SAME(a_no_overflow, clk, arst_n, push, !full || pop, "queue push while full")
	`JHSE_ASSERT_SAME(a_no_underflow, clk, arst_n, pop, not_empty, "queue pop while empty")

endmodule

// ===== rtl/jhse_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Encoder back end
// Applies table writes, looks up Huffman codes and forms output chunks.
// ---------------------------------------------------------------------------
module jhse_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 not_empty,
	input  jhse_pkg::jhse_item_t head,
	output logic                 pop,
	jhse_chunk_if.source         chunk
);
	import jhse_pkg::*;

	`include "jpeg_huffman_symbol_encoder_core_macros.svh"

	localparam int DC_AW = $clog2(DC_DEPTH);
	localparam int AC_AW = $clog2(AC_DEPTH);

	logic                dc_wr, ac_wr, dc_rd, ac_rd;
	logic [ENTRY_W-1:0]  dc_rd_data, ac_rd_data;
	logic [DC_DEPTH-1:0] dc_vld_q;
	logic [AC_DEPTH-1:0] ac_vld_q;

	logic                s1_valid;
	logic                s1_is_dc;
	logic                s1_hit;
	logic [CAT_W-1:0]    s1_cat;
	logic [MAG_W-1:0]    s1_extra;
	logic                s1_bend;
	logic                s1_ready;
	logic                s1_adv;

	logic                out_valid_q;
	logic [CHUNK_W-1:0]  out_chunk_q;
	logic [LEN_W-1:0]    out_len_q;
	logic                out_bend_q;
	logic                out_miss_q;
	logic                out_can;

	logic [ENTRY_W-1:0]  entry;
	logic [LEN_W-1:0]    hlen;
	logic [CODE_W-1:0]   hbits;
	logic                missing;

	assign out_can  = !out_valid_q || chunk.ready;
	assign s1_ready = !s1_valid || out_can;
	assign s1_adv   = s1_valid && out_can;
	assign pop      = not_empty && s1_ready;

	assign dc_wr = pop && (head.op == OP_WR_DC);
	assign ac_wr = pop && (head.op == OP_WR_AC);
	assign dc_rd = pop && (head.op == OP_ENC_DC);
	assign ac_rd = pop && (head.op == OP_ENC_AC);

	jhse_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DC_DEPTH)
	) u_dc_ram (
		.clk     (clk),
		.wr_en   (dc_wr),
		.wr_addr (head.addr[DC_AW-1:0]),
		.wr_data ({head.len, head.code}),
		.rd_en   (dc_rd),
		.rd_addr (head.addr[DC_AW-1:0]),
		.rd_data (dc_rd_data)
	);

	jhse_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (AC_DEPTH)
	) u_ac_ram (
		.clk     (clk),
		.wr_en   (ac_wr),
		.wr_addr (head.addr[AC_AW-1:0]),
		.wr_data ({head.len, head.code}),
		.rd_en   (ac_rd),
		.rd_addr (head.addr[AC_AW-1:0]),
		.rd_data (ac_rd_data)
	);

	// An entry never written reads as empty through its cleared valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_vld_q    <= '0;
			ac_vld_q    <= '0;
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (dc_wr) begin
				dc_vld_q[head.addr[DC_AW-1:0]] <= 1'b1;
			end
			if (ac_wr) begin
				ac_vld_q[head.addr[AC_AW-1:0]] <= 1'b1;
			end
			if (s1_ready) begin
				s1_valid <= dc_rd || ac_rd;
			end
			if (out_can) begin
				out_valid_q <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s1_is_dc <= (head.op == OP_ENC_DC);
			s1_hit   <= (head.op == OP_ENC_DC) ? dc_vld_q[head.addr[DC_AW-1:0]] :
				ac_vld_q[head.addr[AC_AW-1:0]];
			s1_cat   <= head.cat;
			s1_extra <= head.extra;
			s1_bend  <= head.bend;
		end
		if (s1_adv) begin
			out_chunk_q <= missing ? '0 :
				((CHUNK_W'(hbits) << s1_cat) | CHUNK_W'(s1_extra));
			out_len_q   <= missing ? '0 : (hlen + LEN_W'(s1_cat));
			out_bend_q  <= s1_bend;
			out_miss_q  <= missing;
		end
	end

	assign entry   = s1_is_dc ? dc_rd_data : ac_rd_data;
	assign hlen    = s1_hit ? entry[ENTRY_W-1:CODE_W] : '0;
	assign hbits   = entry[CODE_W-1:0];
	assign missing = (hlen == '0);

	assign chunk.valid         = out_valid_q;
	assign chunk.bit_chunk     = out_chunk_q;
	assign chunk.chunk_length  = out_len_q;
	assign chunk.block_end_out = out_bend_q;
	assign chunk.code_missing  = out_miss_q;

	`JHSE_ASSERT_SAME(a_single_ram_port, clk, arst_n, ac_wr || dc_wr, !ac_rd && !dc_rd, "table write and lookup in one cycle")
	`JHSE_ASSERT_SAME(a_missing_empty, clk, arst_n, out_valid_q && out_miss_q, out_len_q == '0 && out_chunk_q == '0, "missing code with nonzero chunk")
	`JHSE_ASSERT_NEXT(a_stall_holds_s1, clk, arst_n, s1_valid && !out_can, s1_valid, "stalled lookup lost")

endmodule

// ===== rtl/jpeg_huffman_symbol_encoder_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JPEG Huffman symbol encoder core
// Baseline JPEG entropy coder for one DC or AC symbol per request.
// ---------------------------------------------------------------------------
// The block takes one request per clock while the queue has room and
// returns one chunk per encode request, none per table write. A request is
// accepted whenever the four-entry queue behind the front end has room, so
// requests stream back to back. An encode result leaves the queue, passes
// through the registered read of the code table memory, and the output
// register then presents it. Both code tables read as empty after reset
// through per-entry valid bits, so there is no clearing pass. Writes and
// encodes take effect strictly in request order.
module jpeg_huffman_symbol_encoder_core #(
	parameter int MAX_CODE_LEN = 16,
	parameter int AMP_BITS     = 11
) (
	input  logic         clk,
	input  logic         arst_n,
	jhse_symbol_if.sink  symbol,
	jhse_chunk_if.source chunk
);
	import jhse_pkg::*;

	logic       push;
	jhse_item_t push_item;
	logic       queue_full;
	logic       not_empty;
	logic       pop;
	jhse_item_t head;

	jhse_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.AMP_BITS     (AMP_BITS)
	) u_front (
		.symbol     (symbol),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	jhse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.not_empty (not_empty),
		.pop       (pop),
		.head      (head)
	);

	jhse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.chunk     (chunk)
	);

endmodule
